@@ src/sifr_pkg.sv @@
package sifr_pkg;

    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_FLAG_BYTE       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE_BYTE     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ESC_FLAG_CODE   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ESC_ESCAPE_CODE = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ADDRESS_BYTE    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_CONTROL_SEQ0    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_CONTROL_SEQ1    = 3'd6;

    localparam logic [7:0] RST_FLAG_BYTE       = 8'd126;
    localparam logic [7:0] RST_ESCAPE_BYTE     = 8'd125;
    localparam logic [7:0] RST_ESC_FLAG_CODE   = 8'd94;
    localparam logic [7:0] RST_ESC_ESCAPE_CODE = 8'd93;
    localparam logic [7:0] RST_ADDRESS_BYTE    = 8'd3;
    localparam logic [7:0] RST_CONTROL_SEQ0    = 8'd0;
    localparam logic [7:0] RST_CONTROL_SEQ1    = 8'd64;

    localparam int LenW = 13;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
    localparam logic [1:0] VERDICT_DATA_ERR  = 2'd1;
    localparam logic [1:0] VERDICT_DUPLICATE = 2'd2;

    localparam logic ACK_RR  = 1'b0;
    localparam logic ACK_REJ = 1'b1;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] escaped_flag_code;
        logic [7:0] escaped_escape_code;
        logic [7:0] address_byte;
        logic [7:0] control_seq0;
        logic [7:0] control_seq1;
    } t_cfg;

    typedef struct packed {
        logic            kind;
        logic [LenW-1:0] frame_length;
        logic            ack_seq;
        logic            ack_is_reject;
        logic [1:0]      verdict;
        logic [7:0]      data_byte;
    } t_result;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_ADDR = 6'b000010,
        PH_CTRL = 6'b000100,
        PH_HCHK = 6'b001000,
        PH_DATA = 6'b010000,
        PH_ESC  = 6'b100000
    } t_phase;

endpackage

@@ src/stuffed_info_frame_receiver.sv @@
// The parser builds each result combinationally; the output buffer registers it.
// Throughput: one line byte per cycle while s_axis_tready is high; the header parser
// and destuffer handle each byte combinationally, and the two-entry output buffer keeps
// s_axis_tready high while one result waits on m_axis, dropping it when both are full.
// Reset: synchronous, active low; config and state registers return to their defaults,
// the parser hunts for a flag, and both output entries are emptied.
module stuffed_info_frame_receiver #(
    parameter int MAX_FRAME_LEN = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [9:8] verdict, [10] ack_is_reject,
                                        // [11] ack_seq, [24:12] frame_length, [31:25] zero
    output logic        m_axis_tuser,   // [0] kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    sifr_pkg::t_cfg    cfg;
    sifr_pkg::t_result res;
    sifr_pkg::t_result out_res;
    logic              res_valid;
    logic              in_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    sifr_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    sifr_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_rx_byte   (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sifr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_in_ready  (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {7'b0, out_res.frame_length, out_res.ack_seq, out_res.ack_is_reject,
                           out_res.verdict, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

@@ src/sifr_cfg_regs.sv @@
module sifr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [sifr_pkg::CfgIdxW-1:0]  i_wr_index,
    input  logic [7:0]                    i_wr_data,
    output sifr_pkg::t_cfg                o_cfg
);

    sifr_pkg::t_cfg r_cfg;
    sifr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                sifr_pkg::CFG_FLAG_BYTE:       n_cfg.flag_byte           = i_wr_data;
                sifr_pkg::CFG_ESCAPE_BYTE:     n_cfg.escape_byte         = i_wr_data;
                sifr_pkg::CFG_ESC_FLAG_CODE:   n_cfg.escaped_flag_code   = i_wr_data;
                sifr_pkg::CFG_ESC_ESCAPE_CODE: n_cfg.escaped_escape_code = i_wr_data;
                sifr_pkg::CFG_ADDRESS_BYTE:    n_cfg.address_byte        = i_wr_data;
                sifr_pkg::CFG_CONTROL_SEQ0:    n_cfg.control_seq0        = i_wr_data;
                sifr_pkg::CFG_CONTROL_SEQ1:    n_cfg.control_seq1        = i_wr_data;
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte           <= sifr_pkg::RST_FLAG_BYTE;
            r_cfg.escape_byte         <= sifr_pkg::RST_ESCAPE_BYTE;
            r_cfg.escaped_flag_code   <= sifr_pkg::RST_ESC_FLAG_CODE;
            r_cfg.escaped_escape_code <= sifr_pkg::RST_ESC_ESCAPE_CODE;
            r_cfg.address_byte        <= sifr_pkg::RST_ADDRESS_BYTE;
            r_cfg.control_seq0        <= sifr_pkg::RST_CONTROL_SEQ0;
            r_cfg.control_seq1        <= sifr_pkg::RST_CONTROL_SEQ1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/sifr_parser.sv @@
module sifr_parser #(
    parameter int MAX_FRAME_LEN = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sifr_pkg::t_cfg    i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    output sifr_pkg::t_result o_res
);

    localparam int CntW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_LEN);

    sifr_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_saved_ctrl, n_saved_ctrl;
    logic             r_rx_seq, n_rx_seq;
    logic             r_exp_seq, n_exp_seq;
    logic [7:0]       r_pend_byte, n_pend_byte;
    logic             r_pend_valid, n_pend_valid;
    logic [7:0]       r_xor, n_xor;
    logic [CntW-1:0]  r_count, n_count;

    logic             push_en;
    logic [7:0]       push_data;
    logic [CntW+sifr_pkg::LenW-1:0] len_ext;

    assign len_ext = {{sifr_pkg::LenW{1'b0}}, r_count};

    always_comb begin
        n_phase      = r_phase;
        n_saved_ctrl = r_saved_ctrl;
        n_rx_seq     = r_rx_seq;
        n_exp_seq    = r_exp_seq;
        n_pend_byte  = r_pend_byte;
        n_pend_valid = r_pend_valid;
        n_xor        = r_xor;
        n_count      = r_count;
        push_en      = 1'b0;
        push_data    = i_rx_byte;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_accept) begin
            case (r_phase)
                sifr_pkg::PH_HUNT: begin
                    if (i_rx_byte == i_cfg.flag_byte) begin
                        n_phase = sifr_pkg::PH_ADDR;
                    end
                end
                sifr_pkg::PH_ADDR: begin
                    if (i_rx_byte == i_cfg.address_byte) begin
                        n_phase = sifr_pkg::PH_CTRL;
                    end else if (i_rx_byte == i_cfg.flag_byte) begin
                        n_phase = sifr_pkg::PH_ADDR;
                    end else begin
                        n_phase = sifr_pkg::PH_HUNT;
                    end
                end
                sifr_pkg::PH_CTRL: begin
                    if (i_rx_byte == i_cfg.control_seq0 || i_rx_byte == i_cfg.control_seq1) begin
                        n_saved_ctrl = i_rx_byte;
                        n_rx_seq     = (i_rx_byte != i_cfg.control_seq0);
                        n_phase      = sifr_pkg::PH_HCHK;
                    end else if (i_rx_byte == i_cfg.flag_byte) begin
                        n_phase = sifr_pkg::PH_ADDR;
                    end else begin
                        n_phase = sifr_pkg::PH_HUNT;
                    end
                end
                sifr_pkg::PH_HCHK: begin
                    if (i_rx_byte == (i_cfg.address_byte ^ r_saved_ctrl)) begin
                        n_phase      = sifr_pkg::PH_DATA;
                        n_pend_byte  = '0;
                        n_pend_valid = 1'b0;
                        n_xor        = '0;
                        n_count      = '0;
                    end else begin
                        n_phase = sifr_pkg::PH_HUNT;
                    end
                end
                sifr_pkg::PH_DATA: begin
                    if (i_rx_byte == i_cfg.flag_byte) begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = sifr_pkg::KIND_VERDICT;
                        o_res.frame_length = len_ext[sifr_pkg::LenW-1:0];
                        n_phase            = sifr_pkg::PH_HUNT;
                        if (r_rx_seq != r_exp_seq) begin
                            o_res.verdict       = sifr_pkg::VERDICT_DUPLICATE;
                            o_res.ack_is_reject = sifr_pkg::ACK_REJ;
                            o_res.ack_seq       = ~r_rx_seq;
                        end else if (r_pend_valid && r_xor == r_pend_byte) begin
                            o_res.verdict       = sifr_pkg::VERDICT_ACCEPTED;
                            o_res.ack_is_reject = sifr_pkg::ACK_RR;
                            o_res.ack_seq       = ~r_rx_seq;
                            n_exp_seq           = ~r_exp_seq;
                        end else begin
                            o_res.verdict       = sifr_pkg::VERDICT_DATA_ERR;
                            o_res.ack_is_reject = sifr_pkg::ACK_REJ;
                            o_res.ack_seq       = r_rx_seq;
                        end
                    end else if (i_rx_byte == i_cfg.escape_byte) begin
                        n_phase = sifr_pkg::PH_ESC;
                    end else begin
                        push_en = 1'b1;
                    end
                end
                sifr_pkg::PH_ESC: begin
                    n_phase = sifr_pkg::PH_DATA;
                    if (i_rx_byte == i_cfg.escaped_flag_code) begin
                        push_en   = 1'b1;
                        push_data = i_cfg.flag_byte;
                    end else if (i_rx_byte == i_cfg.escaped_escape_code) begin
                        push_en   = 1'b1;
                        push_data = i_cfg.escape_byte;
                    end
                end
                default: begin
                    n_phase = sifr_pkg::PH_HUNT;
                end
            endcase

            if (push_en) begin
                if (r_pend_valid) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = sifr_pkg::KIND_DATA;
                    o_res.data_byte = r_pend_byte;
                    n_xor           = r_xor ^ r_pend_byte;
                    if (r_count < CntMax) begin
                        n_count = r_count + CntW'(1);
                    end
                end
                n_pend_byte  = push_data;
                n_pend_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sifr_pkg::PH_HUNT;
            r_rx_seq     <= 1'b0;
            r_exp_seq    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_xor        <= '0;
            r_count      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_rx_seq     <= n_rx_seq;
            r_exp_seq    <= n_exp_seq;
            r_pend_valid <= n_pend_valid;
            r_xor        <= n_xor;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved_ctrl <= n_saved_ctrl;
        r_pend_byte  <= n_pend_byte;
    end

endmodule

@@ src/sifr_out_buf.sv @@
module sifr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  sifr_pkg::t_result i_res,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output sifr_pkg::t_result o_res
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    sifr_pkg::t_result r_out, n_out;
    sifr_pkg::t_result r_skid, n_skid;
    logic              out_take;

    assign out_take   = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || out_take) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

@@ dv/stuffed_info_frame_receiver_tb.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxFrameLen = 4096;
    localparam int CycleLimit  = 400000;
    localparam int PhaseBytes  = 160;

    typedef enum {CHK_GOOD, CHK_BAD, CHK_NONE} t_chk_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [7:0] data_byte, [9:8] verdict, [10] ack_is_reject,
                                          // [11] ack_seq, [24:12] frame_length, [31:25] zero
    logic        m_axis_tuser;            // [0] kind
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = sifr_pkg::CFG_FLAG_BYTE;
    logic [7:0]  i_cfg_data    = 8'h00;

    stuffed_info_frame_receiver #(
        .MAX_FRAME_LEN(MaxFrameLen)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // receiver state mirror
    sifr_pkg::t_cfg            reg_mirror;
    sifr_pkg::t_phase          rx_phase;
    logic [7:0]                hdr_control;
    logic                      rx_seq;
    logic                      next_seq;
    logic [7:0]                held_byte;
    logic                      held_valid;
    logic [7:0]                payload_xor;
    logic [sifr_pkg::LenW-1:0] payload_len;

    sifr_pkg::t_result decoded_q[$];

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int err_cnt;
    int cycle_cnt;
    int frame_bytes;
    int frames_closed;
    int data_results;
    int settings_used;
    int verdict_cnt[3];

    function automatic void mirror_reset();
        reg_mirror = '{sifr_pkg::RST_FLAG_BYTE, sifr_pkg::RST_ESCAPE_BYTE,
                       sifr_pkg::RST_ESC_FLAG_CODE, sifr_pkg::RST_ESC_ESCAPE_CODE,
                       sifr_pkg::RST_ADDRESS_BYTE, sifr_pkg::RST_CONTROL_SEQ0,
                       sifr_pkg::RST_CONTROL_SEQ1};
        rx_phase    = sifr_pkg::PH_HUNT;
        hdr_control = 8'h00;
        rx_seq      = 1'b0;
        next_seq    = 1'b0;
        held_byte   = 8'h00;
        held_valid  = 1'b0;
        payload_xor = 8'h00;
        payload_len = '0;
    endfunction

    function automatic void push_payload(input logic [7:0] d);
        sifr_pkg::t_result r;
        if (held_valid) begin
            r = '0;
            r.kind = sifr_pkg::KIND_DATA;
            r.data_byte = held_byte;
            decoded_q.push_back(r);
            payload_xor ^= held_byte;
            if (payload_len < sifr_pkg::LenW'(MaxFrameLen)) payload_len++;
            data_results++;
        end
        held_byte  = d;
        held_valid = 1'b1;
    endfunction

    function automatic void close_frame();
        sifr_pkg::t_result r;
        r = '0;
        r.kind = sifr_pkg::KIND_VERDICT;
        r.frame_length = payload_len;
        if (rx_seq != next_seq) begin
            r.verdict = sifr_pkg::VERDICT_DUPLICATE;
            r.ack_is_reject = sifr_pkg::ACK_REJ;
            r.ack_seq = ~rx_seq;
        end else if (held_valid && payload_xor == held_byte) begin
            r.verdict = sifr_pkg::VERDICT_ACCEPTED;
            r.ack_is_reject = sifr_pkg::ACK_RR;
            r.ack_seq = ~rx_seq;
            next_seq = ~next_seq;
        end else begin
            r.verdict = sifr_pkg::VERDICT_DATA_ERR;
            r.ack_is_reject = sifr_pkg::ACK_REJ;
            r.ack_seq = rx_seq;
        end
        decoded_q.push_back(r);
        verdict_cnt[r.verdict]++;
        frames_closed++;
        rx_phase = sifr_pkg::PH_HUNT;
    endfunction

    function automatic void decode_line_byte(input logic [7:0] b);
        if (rx_phase != sifr_pkg::PH_HUNT || b == reg_mirror.flag_byte) frame_bytes++;
        case (rx_phase)
            sifr_pkg::PH_HUNT: begin
                if (b == reg_mirror.flag_byte) rx_phase = sifr_pkg::PH_ADDR;
            end
            sifr_pkg::PH_ADDR: begin
                if (b == reg_mirror.address_byte) rx_phase = sifr_pkg::PH_CTRL;
                else if (b == reg_mirror.flag_byte) rx_phase = sifr_pkg::PH_ADDR;
                else rx_phase = sifr_pkg::PH_HUNT;
            end
            sifr_pkg::PH_CTRL: begin
                if (b == reg_mirror.control_seq0 || b == reg_mirror.control_seq1) begin
                    hdr_control = b;
                    rx_seq = (b == reg_mirror.control_seq0) ? 1'b0 : 1'b1;
                    rx_phase = sifr_pkg::PH_HCHK;
                end else if (b == reg_mirror.flag_byte) begin
                    rx_phase = sifr_pkg::PH_ADDR;
                end else begin
                    rx_phase = sifr_pkg::PH_HUNT;
                end
            end
            sifr_pkg::PH_HCHK: begin
                if (b == (reg_mirror.address_byte ^ hdr_control)) begin
                    rx_phase    = sifr_pkg::PH_DATA;
                    held_byte   = 8'h00;
                    held_valid  = 1'b0;
                    payload_xor = 8'h00;
                    payload_len = '0;
                end else begin
                    rx_phase = sifr_pkg::PH_HUNT;
                end
            end
            sifr_pkg::PH_DATA: begin
                if (b == reg_mirror.flag_byte) close_frame();
                else if (b == reg_mirror.escape_byte) rx_phase = sifr_pkg::PH_ESC;
                else push_payload(b);
            end
            sifr_pkg::PH_ESC: begin
                rx_phase = sifr_pkg::PH_DATA;
                if (b == reg_mirror.escaped_flag_code) push_payload(reg_mirror.flag_byte);
                else if (b == reg_mirror.escaped_escape_code) push_payload(reg_mirror.escape_byte);
            end
            default: rx_phase = sifr_pkg::PH_HUNT;
        endcase
    endfunction

    function automatic void mirror_reg(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            sifr_pkg::CFG_FLAG_BYTE:       reg_mirror.flag_byte = val;
            sifr_pkg::CFG_ESCAPE_BYTE:     reg_mirror.escape_byte = val;
            sifr_pkg::CFG_ESC_FLAG_CODE:   reg_mirror.escaped_flag_code = val;
            sifr_pkg::CFG_ESC_ESCAPE_CODE: reg_mirror.escaped_escape_code = val;
            sifr_pkg::CFG_ADDRESS_BYTE:    reg_mirror.address_byte = val;
            sifr_pkg::CFG_CONTROL_SEQ0:    reg_mirror.control_seq0 = val;
            sifr_pkg::CFG_CONTROL_SEQ1:    reg_mirror.control_seq1 = val;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_stalls || ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        sifr_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result with none pending: kind %0b tdata %h", m_axis_tuser, m_axis_tdata);
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
                check_field("verdict", want.verdict, m_axis_tdata[9:8]);
                check_field("ack_is_reject", want.ack_is_reject, m_axis_tdata[10]);
                check_field("ack_seq", want.ack_seq, m_axis_tdata[11]);
                check_field("frame_length", want.frame_length, m_axis_tdata[24:12]);
                check_field("pad", 32'd0, m_axis_tdata[31:25]);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (tx_gaps && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_line_byte(b);
    endtask

    task automatic send_stuffed(input logic [7:0] d);
        if (d == reg_mirror.flag_byte) begin
            send_byte(reg_mirror.escape_byte);
            send_byte(reg_mirror.escaped_flag_code);
        end else if (d == reg_mirror.escape_byte) begin
            send_byte(reg_mirror.escape_byte);
            send_byte(reg_mirror.escaped_escape_code);
        end else begin
            send_byte(d);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 20) return reg_mirror.flag_byte;
        if (r < 35) return reg_mirror.escape_byte;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] control_for(input logic s);
        return s ? reg_mirror.control_seq1 : reg_mirror.control_seq0;
    endfunction

    task automatic send_frame(input logic [7:0] ctrl, input int len, input t_chk_mode mode,
                              input bit hdr_ok, input bit junk_esc);
        logic [7:0] d;
        logic [7:0] chk;
        chk = 8'h00;
        send_byte(reg_mirror.flag_byte);
        send_byte(reg_mirror.address_byte);
        send_byte(ctrl);
        send_byte((reg_mirror.address_byte ^ ctrl) ^ (hdr_ok ? 8'h00 : 8'h01));
        for (int i = 0; i < len; i++) begin
            if (junk_esc && $urandom_range(7) == 0) begin
                send_byte(reg_mirror.escape_byte);
                send_byte(8'($urandom_range(255)));
            end
            d = pick_payload();
            chk ^= d;
            send_stuffed(d);
        end
        if (mode == CHK_GOOD) send_stuffed(chk);
        else if (mode == CHK_BAD) send_stuffed(chk ^ 8'($urandom_range(1, 255)));
        send_byte(reg_mirror.flag_byte);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input sifr_pkg::t_cfg c);
        logic [2:0] idx[7];
        logic [7:0] val[7];
        idx = '{sifr_pkg::CFG_FLAG_BYTE, sifr_pkg::CFG_ESCAPE_BYTE,
                sifr_pkg::CFG_ESC_FLAG_CODE, sifr_pkg::CFG_ESC_ESCAPE_CODE,
                sifr_pkg::CFG_ADDRESS_BYTE, sifr_pkg::CFG_CONTROL_SEQ0,
                sifr_pkg::CFG_CONTROL_SEQ1};
        val = '{c.flag_byte, c.escape_byte, c.escaped_flag_code, c.escaped_escape_code,
                c.address_byte, c.control_seq0, c.control_seq1};
        drain();
        for (int i = 0; i < 7; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            mirror_reg(idx[i], val[i]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic sifr_pkg::t_cfg random_settings();
        sifr_pkg::t_cfg c;
        c.flag_byte = 8'($urandom_range(255));
        do c.escape_byte = 8'($urandom_range(255)); while (c.escape_byte == c.flag_byte);
        c.escaped_flag_code = 8'($urandom_range(255));
        do c.escaped_escape_code = 8'($urandom_range(255));
        while (c.escaped_escape_code == c.escaped_flag_code);
        c.address_byte = 8'($urandom_range(255));
        c.control_seq0 = 8'($urandom_range(255));
        do c.control_seq1 = 8'($urandom_range(255)); while (c.control_seq1 == c.control_seq0);
        return c;
    endfunction

    task automatic test_header_cases();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(reg_mirror.flag_byte);
        send_byte(8'h55);
        send_byte(reg_mirror.flag_byte);
        send_byte(reg_mirror.flag_byte);
        send_byte(reg_mirror.address_byte);
        send_byte(reg_mirror.flag_byte);
        send_byte(reg_mirror.address_byte);
        send_byte(reg_mirror.control_seq0);
        send_byte(reg_mirror.flag_byte);
        send_frame(control_for(next_seq), 1, CHK_GOOD, 1'b0, 1'b0);
    endtask

    task automatic test_escape_cases();
        logic [7:0] chk;
        chk = reg_mirror.flag_byte ^ reg_mirror.escape_byte ^ 8'h00 ^ 8'hFF;
        send_byte(reg_mirror.flag_byte);
        send_byte(reg_mirror.address_byte);
        send_byte(control_for(next_seq));
        send_byte(reg_mirror.address_byte ^ control_for(next_seq));
        send_byte(reg_mirror.escape_byte);
        send_byte(reg_mirror.escaped_flag_code);
        send_byte(reg_mirror.escape_byte);
        send_byte(reg_mirror.escaped_escape_code);
        send_byte(reg_mirror.escape_byte);
        send_byte(8'h41);
        send_byte(reg_mirror.escape_byte);
        send_byte(reg_mirror.flag_byte);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_stuffed(chk);
        send_byte(reg_mirror.flag_byte);
    endtask

    task automatic test_verdicts();
        logic s;
        s = next_seq;
        send_frame(control_for(s), 2, CHK_GOOD, 1'b1, 1'b0);
        send_frame(control_for(s), 2, CHK_GOOD, 1'b1, 1'b0);
        send_frame(control_for(~s), 2, CHK_BAD, 1'b1, 1'b0);
        send_frame(control_for(~s), 0, CHK_NONE, 1'b1, 1'b0);
        send_frame(control_for(~s), 0, CHK_GOOD, 1'b1, 1'b0);
    endtask

    task automatic test_equal_controls();
        sifr_pkg::t_cfg c;
        c = reg_mirror;
        c.control_seq0 = 8'h5A;
        c.control_seq1 = 8'h5A;
        apply_settings(c);
        send_frame(8'h5A, 3, CHK_GOOD, 1'b1, 1'b0);
        send_frame(8'h5A, 3, CHK_GOOD, 1'b1, 1'b0);
    endtask

    task automatic test_long_frame();
        apply_settings(random_settings());
        send_frame(control_for(next_seq), 60, CHK_GOOD, 1'b1, 1'b0);
    endtask

    task automatic run_random_phase(input sifr_pkg::t_cfg c);
        int start;
        int r;
        apply_settings(c);
        start = frame_bytes;
        while (frame_bytes - start < PhaseBytes) begin
            r = $urandom_range(99);
            if (r < 82) begin
                send_frame(($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                     : control_for(1'($urandom_range(1))),
                           ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12),
                           t_chk_mode'(($urandom_range(9) < 8) ? CHK_GOOD
                                       : $urandom_range(1) ? CHK_BAD : CHK_NONE),
                           $urandom_range(29) != 0, $urandom_range(4) == 0);
            end else if (r < 92) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(reg_mirror.flag_byte);
                if ($urandom_range(1)) send_byte(reg_mirror.address_byte);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase('{sifr_pkg::RST_FLAG_BYTE, sifr_pkg::RST_ESCAPE_BYTE,
                           sifr_pkg::RST_ESC_FLAG_CODE, sifr_pkg::RST_ESC_ESCAPE_CODE,
                           sifr_pkg::RST_ADDRESS_BYTE, sifr_pkg::RST_CONTROL_SEQ0,
                           sifr_pkg::RST_CONTROL_SEQ1});
        run_random_phase('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF});
        run_random_phase('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00});
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        run_random_phase(random_settings());
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        run_random_phase(random_settings());
        run_random_phase(random_settings());
    endtask

    initial begin
        mirror_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_cases();
        test_escape_cases();
        test_verdicts();
        test_equal_controls();
        test_long_frame();
        test_random_traffic();
        drain();
        repeat (8) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d results never arrived", decoded_q.size());
            err_cnt++;
        end
        $display("Sent %0d in-frame line bytes, %0d frames closed, %0d payload bytes out,",
                 frame_bytes, frames_closed, data_results);
        $display("verdicts ok/bad/dup %0d/%0d/%0d over %0d register settings.",
                 verdict_cnt[0], verdict_cnt[1], verdict_cnt[2], settings_used);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
